>>> hdl/sfs_pkg.sv
// shared types and constants of the sprite frame sequencer
package sfs_pkg;

  localparam int unsigned FRAME_W    = 13;
  localparam int unsigned COL_W      = 6;
  localparam int unsigned DIM_W      = 7;
  localparam int unsigned FIRST_W    = 6;
  localparam int unsigned LEN_W      = 12;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // request codes carried by an input beat
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK = 2'd0,
    MODE_PLAY = 2'd1,
    MODE_STOP = 2'd2
  } sfs_mode_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_COLUMNS = 3'd0,
    CFG_GRID_ROWS    = 3'd1,
    CFG_FIRST_COLUMN = 3'd2,
    CFG_FIRST_ROW    = 3'd3,
    CFG_RUN_LENGTH   = 3'd4,
    CFG_FRAME_PERIOD = 3'd5,
    CFG_REVERSE      = 3'd6
  } sfs_cfg_reg_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LAUNCH,
    ST_TDIV,
    ST_GDIV,
    ST_HOLD
  } sfs_state_e;

  // status of a serial divider
  typedef struct packed {
    logic busy;
    logic done;
    logic qbit;
  } sfs_div_stat_t;

endpackage

>>> hdl/sfs_in_if.sv
// input channel: request beats into the sequencer
interface sfs_in_if #(
  parameter int unsigned TIME_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [TIME_BITS-1:0] elapsed;

  modport source (output valid, output mode, output elapsed, input ready);
  modport sink   (input valid, input mode, input elapsed, output ready);
endinterface

>>> hdl/sfs_out_if.sv
// output channel: frame report beats from the sequencer
interface sfs_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] frame_index;
  logic [5:0]  column;
  logic [12:0] row;
  logic        is_playing;
  logic        frame_changed;

  modport source (output valid, output frame_index, output column, output row,
                  output is_playing, output frame_changed, input ready);
  modport sink   (input valid, input frame_index, input column, input row,
                  input is_playing, input frame_changed, output ready);
endinterface

>>> hdl/sfs_sdiv.sv
// bit-serial restoring divider, one quotient bit per cycle, msb first
module sfs_sdiv import sfs_pkg::*; #(
  parameter int unsigned DW = 13,
  parameter int unsigned VW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output sfs_div_stat_t stat_o,
  output logic [DW-1:0] quot_o,
  output logic [VW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_q, quot_q;
  logic [VW-1:0]   rem_q, div_q, rem_nx;
  logic [CntW-1:0] cnt_q;
  logic            done_q, busy, ge;
  logic [VW:0]     trial, diff;

  // one restoring step: bring down the next dividend bit
  assign busy   = (cnt_q != '0);
  assign trial  = {rem_q, dvd_q[DW-1]};
  assign ge     = (trial >= {1'b0, div_q});
  assign diff   = trial - {1'b0, div_q};
  assign rem_nx = ge ? diff[VW-1:0] : trial[VW-1:0];

  // step counter and completion pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy && (cnt_q == CntW'(1));
      if (start_i) begin
        cnt_q <= CntW'(DW);
      end else if (busy) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // dividend shift register, partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      div_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= rem_nx;
      quot_q <= {quot_q[DW-2:0], ge};
    end
  end

  assign stat_o.busy = busy;
  assign stat_o.done = done_q;
  assign stat_o.qbit = ge;
  assign quot_o      = quot_q;
  assign rem_o       = rem_q;

endmodule

>>> hdl/sprite_frame_sequencer.sv
// Sprite sheet flipbook sequencer: tick / play / stop requests step a frame run.
// A tick that advances steps through PREP, LAUNCH, TDIV, GDIV and HOLD; any other
// request skips TDIV. TDIV is the serial divide of the time accumulator by the frame
// period, GDIV the serial divide of the frame by the column count. HOLD waits for a
// free output register; a new beat is taken only once the result has been loaded.
// Reset is asynchronous: frame, accumulator and play flag clear, registers load defaults.
module sprite_frame_sequencer import sfs_pkg::*; #(
  parameter int unsigned GRID_DIM  = 64,
  parameter int unsigned TIME_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  sfs_in_if.sink                in_i,
  sfs_out_if.source             out_o
);

  localparam int unsigned AccW = ((TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W) + 1;
  localparam int unsigned EndW = FRAME_W + 1;

  // configuration registers
  logic [DIM_W-1:0]    cols_q, rows_q, cols_d, rows_d;
  logic [FIRST_W-1:0]  fcol_q, frow_q, fcol_d, frow_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic                rev_q, rev_d;

  // animation state
  sfs_state_e          state_q, state_d;
  logic [FRAME_W-1:0]  frame_q, frame_d;
  logic [PERIOD_W-1:0] accum_q, accum_d;
  logic                play_q, play_d;
  logic                out_valid_q, out_valid_d;

  // per-beat working registers
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [TIME_BITS-1:0] elap_q, elap_d;
  logic [FRAME_W-1:0]   start_q, start_d;
  logic [LEN_W-1:0]     off_q, off_d, nm_q, nm_d;
  logic                 chg_q, chg_d;

  // output payload
  logic [FRAME_W-1:0] o_frame_q, o_frame_d, o_row_q, o_row_d;
  logic [COL_W-1:0]   o_col_q, o_col_d;
  logic               o_play_q, o_play_d, o_chg_q, o_chg_d;

  // dividers
  sfs_div_stat_t       tstat, gstat;
  logic                tstart, gstart;
  logic [AccW-1:0]     tsum, tquot;
  logic [PERIOD_W-1:0] trem;
  logic [FRAME_W-1:0]  gquot;
  logic [DIM_W-1:0]    grem;

  // helpers
  logic [EndW-1:0]    end_v, cur_adj, new_sum;
  logic               cur_out, can_adv;
  logic [LEN_W:0]     nm2, fwd, bwd;
  logic [LEN_W-1:0]   new_off;
  logic [FRAME_W-1:0] new_frame;
  logic               out_free;

  assign out_free = !out_valid_q || out_o.ready;

  // run bounds and the tick gate
  always_comb begin
    end_v   = {1'b0, start_q} + EndW'(len_q) - EndW'(1);
    cur_out = (frame_q < start_q) || ({1'b0, frame_q} > end_v);
    can_adv = play_q && (elap_q != '0) && (cols_q != '0) && (rows_q != '0) &&
              (len_q != '0) && (period_q != '0);
    if (cur_out) begin
      cur_adj = rev_q ? end_v : {1'b0, start_q};
    end else begin
      cur_adj = {1'b0, frame_q};
    end
    tsum = AccW'(accum_q) + AccW'(elap_q);
  end

  // new position in the run from the offset and the wrapped frame count
  always_comb begin
    nm2 = {nm_q, tstat.qbit};
    fwd = {1'b0, off_q} + {1'b0, nm_q};
    if (off_q >= nm_q) begin
      bwd = {1'b0, off_q} - {1'b0, nm_q};
    end else begin
      bwd = {1'b0, off_q} + {1'b0, len_q} - {1'b0, nm_q};
    end
    if (rev_q) begin
      new_off = bwd[LEN_W-1:0];
    end else if (fwd >= {1'b0, len_q}) begin
      new_off = LEN_W'(fwd - {1'b0, len_q});
    end else begin
      new_off = fwd[LEN_W-1:0];
    end
    new_sum   = {1'b0, start_q} + EndW'(new_off);
    new_frame = new_sum[FRAME_W-1:0];
  end

  // configuration writes
  always_comb begin
    cols_d   = cols_q;
    rows_d   = rows_q;
    fcol_d   = fcol_q;
    frow_d   = frow_q;
    len_d    = len_q;
    period_d = period_q;
    rev_d    = rev_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_COLUMNS: begin
          cols_d = (32'(cfg_data_i[DIM_W-1:0]) > GRID_DIM) ? DIM_W'(GRID_DIM)
                                                           : cfg_data_i[DIM_W-1:0];
        end
        CFG_GRID_ROWS: begin
          rows_d = (32'(cfg_data_i[DIM_W-1:0]) > GRID_DIM) ? DIM_W'(GRID_DIM)
                                                           : cfg_data_i[DIM_W-1:0];
        end
        CFG_FIRST_COLUMN: fcol_d   = cfg_data_i[FIRST_W-1:0];
        CFG_FIRST_ROW:    frow_d   = cfg_data_i[FIRST_W-1:0];
        CFG_RUN_LENGTH:   len_d    = cfg_data_i[LEN_W-1:0];
        CFG_FRAME_PERIOD: period_d = cfg_data_i[PERIOD_W-1:0];
        CFG_REVERSE:      rev_d    = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer: next state and outputs
  always_comb begin
    state_d     = state_q;
    frame_d     = frame_q;
    accum_d     = accum_q;
    play_d      = play_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mode_d      = mode_q;
    elap_d      = elap_q;
    start_d     = start_q;
    off_d       = off_q;
    nm_d        = nm_q;
    chg_d       = chg_q;
    o_frame_d   = o_frame_q;
    o_col_d     = o_col_q;
    o_row_d     = o_row_q;
    o_play_d    = o_play_q;
    o_chg_d     = o_chg_q;
    tstart      = 1'b0;
    gstart      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          mode_d  = in_i.mode;
          elap_d  = in_i.elapsed;
          state_d = ST_PREP;
        end
      end

      // first frame of the run
      ST_PREP: begin
        start_d = FRAME_W'(FRAME_W'(frow_q) * FRAME_W'(cols_q)) + FRAME_W'(fcol_q);
        state_d = ST_LAUNCH;
      end

      ST_LAUNCH: begin
        chg_d = 1'b0;
        nm_d  = '0;
        off_d = LEN_W'(cur_adj - {1'b0, start_q});
        case (mode_q)
          MODE_TICK: begin
            if (can_adv) begin
              tstart  = 1'b1;
              state_d = ST_TDIV;
            end
          end
          MODE_PLAY: begin
            if (!play_q && (cols_q != '0) && (rows_q != '0)) begin
              frame_d = rev_q ? FRAME_W'(start_q + FRAME_W'(len_q) - FRAME_W'(1))
                              : start_q;
              accum_d = '0;
              play_d  = 1'b1;
              chg_d   = 1'b1;
            end
          end
          MODE_STOP: play_d = 1'b0;
          default: ;
        endcase
        if (!tstart) begin
          gstart  = 1'b1;
          state_d = ST_GDIV;
        end
      end

      // whole periods stream out msb first, folded modulo the run length
      ST_TDIV: begin
        if (tstat.busy) begin
          nm_d = (nm2 >= {1'b0, len_q}) ? LEN_W'(nm2 - {1'b0, len_q}) : nm2[LEN_W-1:0];
        end
        if (tstat.done) begin
          frame_d = new_frame;
          accum_d = trem;
          chg_d   = (new_frame != frame_q);
          gstart  = 1'b1;
          state_d = ST_GDIV;
        end
      end

      ST_GDIV: begin
        if (gstat.done) begin
          state_d = ST_HOLD;
        end
      end

      // load the output register once it is free
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_frame_d   = frame_q;
          o_col_d     = (cols_q != '0) ? grem[COL_W-1:0] : '0;
          o_row_d     = (cols_q != '0) ? gquot : '0;
          o_play_d    = play_q;
          o_chg_d     = chg_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cols_q      <= DIM_W'(1);
      rows_q      <= DIM_W'(1);
      fcol_q      <= '0;
      frow_q      <= '0;
      len_q       <= LEN_W'(1);
      period_q    <= '0;
      rev_q       <= 1'b0;
      frame_q     <= '0;
      accum_q     <= '0;
      play_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cols_q      <= cols_d;
      rows_q      <= rows_d;
      fcol_q      <= fcol_d;
      frow_q      <= frow_d;
      len_q       <= len_d;
      period_q    <= period_d;
      rev_q       <= rev_d;
      frame_q     <= frame_d;
      accum_q     <= accum_d;
      play_q      <= play_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working and payload registers
  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    elap_q    <= elap_d;
    start_q   <= start_d;
    off_q     <= off_d;
    nm_q      <= nm_d;
    chg_q     <= chg_d;
    o_frame_q <= o_frame_d;
    o_col_q   <= o_col_d;
    o_row_q   <= o_row_d;
    o_play_q  <= o_play_d;
    o_chg_q   <= o_chg_d;
  end

  // accumulator over frame period
  sfs_sdiv #(
    .DW (AccW),
    .VW (PERIOD_W)
  ) u_tdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tstart),
    .dividend_i (tsum),
    .divisor_i  (period_q),
    .stat_o     (tstat),
    .quot_o     (tquot),
    .rem_o      (trem)
  );

  // frame over grid columns
  sfs_sdiv #(
    .DW (FRAME_W),
    .VW (DIM_W)
  ) u_gdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (gstart),
    .dividend_i (frame_d),
    .divisor_i  (cols_q),
    .stat_o     (gstat),
    .quot_o     (gquot),
    .rem_o      (grem)
  );

  // the full quotient of the tick divide is only needed bit by bit
  logic tquot_unused;
  assign tquot_unused = ^tquot;

  // channel hookup
  assign in_i.ready          = (state_q == ST_IDLE);
  assign out_o.valid         = out_valid_q;
  assign out_o.frame_index   = o_frame_q;
  assign out_o.column        = o_col_q;
  assign out_o.row           = o_row_q;
  assign out_o.is_playing    = o_play_q;
  assign out_o.frame_changed = o_chg_q;

endmodule
